>>> rtl/fvn_pkg.sv
`timescale 1ns / 1ps

package fvn_pkg;

	localparam int MAX_OCTAVES     = 8;
	localparam int COORD_FRAC_BITS = 16;
	localparam int FRAC_DOWN       = (COORD_FRAC_BITS > 16) ? (COORD_FRAC_BITS - 16) : 0;
	localparam int FRAC_UP         = (COORD_FRAC_BITS < 16) ? (16 - COORD_FRAC_BITS) : 0;

	// Pipeline depths of the parts, in register stages.
	localparam int LANE_LAT   = 7;
	localparam int SUM_LVLS   = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 0;
	localparam int SUM_LEAVES = 1 << SUM_LVLS;
	localparam int SUM_LAT    = SUM_LVLS + 1;
	localparam int Q_BITS     = 16;
	localparam int DIV_LAT    = Q_BITS + 3;
	localparam int PIPE_LAT   = MAX_OCTAVES + LANE_LAT + SUM_LAT + DIV_LAT;

	localparam int PROD_W = 50;
	localparam int TOT_W  = PROD_W + SUM_LVLS;
	localparam int NORM_W = 32 + SUM_LVLS;

	localparam logic [31:0] HASH_MX   = 32'd374761393;
	localparam logic [31:0] HASH_MY   = 32'd668265263;
	localparam logic [31:0] HASH_MIX  = 32'd1274126177;
	localparam logic [31:0] HASH_MASK = 32'h00ffffff;
	localparam logic [31:0] SEED_STEP = 32'd101;
	localparam logic [31:0] FREQ_ONE  = 32'd4096;
	localparam logic [31:0] AMP_ONE   = 32'd65536;

	typedef logic signed [PROD_W-1:0] oct_prod_t;
	typedef logic signed [TOT_W-1:0]  total_t;
	typedef logic [NORM_W-1:0]        norm_t;

	typedef enum logic [1:0] {
		REG_BASE_SEED    = 2'd0,
		REG_OCTAVE_COUNT = 2'd1,
		REG_LACUNARITY   = 2'd2,
		REG_GAIN         = 2'd3
	} reg_idx_t;

	// Unsigned Q4.12 scaling, truncated and saturated to 32 bits.
	function automatic logic [31:0] mul_sat(input logic [31:0] a, input logic [15:0] m);
		logic [47:0] p;
		p = 48'(a) * 48'(m);
		return (|p[47:44]) ? 32'hFFFFFFFF : p[43:12];
	endfunction

endpackage

>>> rtl/fvn_octave.sv
`timescale 1ns / 1ps

module fvn_octave (
	input  logic                clk,
	input  logic                en,
	input  logic signed [31:0]  coord_x,
	input  logic signed [31:0]  coord_y,
	input  logic [31:0]         freq,
	input  logic [31:0]         seed,
	input  logic [31:0]         amp,
	output fvn_pkg::oct_prod_t  prod,
	output logic [31:0]         amp_out
);
	import fvn_pkg::*;

	function automatic logic [15:0] frac_q16(input logic [63:0] s);
		logic [63:0] fr;
		fr = 64'(s[COORD_FRAC_BITS-1:0]);
		return 16'((fr >> FRAC_DOWN) << FRAC_UP);
	endfunction

	function automatic logic [16:0] smooth(input logic [31:0] t2, input logic [15:0] t);
		logic [17:0] w;
		logic [49:0] p;
		w = 18'd196608 - {1'b0, t, 1'b0};
		p = 50'(t2) * 50'(w);
		return 17'((p + 50'h0_8000_0000) >> 32);
	endfunction

	// Maps a 24-bit hash onto [0, 65536]. Division by 2^24-1 is done as a shift
	// plus a fold of the quotient back into the remainder and one compare.
	function automatic logic [16:0] corner_value(input logic [31:0] g);
		logic [23:0] h;
		logic [40:0] nn;
		logic [16:0] q0;
		logic [24:0] r0;
		h  = 24'((g ^ (g >> 16)) & HASH_MASK);
		nn = {1'b0, h, 16'h0} + 41'h7FFFFF;
		q0 = nn[40:24];
		r0 = {1'b0, nn[23:0]} + 25'(q0);
		return q0 + 17'(r0 >= 25'hFFFFFF);
	endfunction

	function automatic logic [16:0] blend(input logic [16:0] a, input logic [16:0] b,
			input logic [16:0] s);
		logic [16:0] sc;
		logic [34:0] acc;
		sc  = 17'd65536 - s;
		acc = 35'(a) * 35'(sc) + 35'(b) * 35'(s) + 35'd32768;
		return 17'(acc >> 16);
	endfunction

	logic signed [63:0] px_s1, py_s1;
	logic [31:0]        seed_s1, amp_s1;

	logic signed [63:0] sx, sy;
	logic [31:0]        cx, cy;
	logic [15:0]        tx, ty;

	logic [31:0] ax0_s2, ax1_s2, by0_s2, by1_s2, t2x_s2, t2y_s2, seed_s2, amp_s2;
	logic [15:0] tx_s2, ty_s2;

	logic [31:0] hc [4];
	logic [31:0] mix_s3 [4];
	logic [16:0] wx_s3, wy_s3;
	logic [31:0] amp_s3;

	logic [16:0] n_s4 [4];
	logic [16:0] wx_s4, wy_s4;
	logic [31:0] amp_s4;

	logic [16:0] r0_s5, r1_s5, wy_s5;
	logic [31:0] amp_s5;

	logic [16:0] n_s6;
	logic [31:0] amp_s6;

	logic signed [18:0] v;
	oct_prod_t          prod_s7;
	logic [31:0]        amp_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1   <= $signed(coord_x) * $signed({1'b0, freq});
			py_s1   <= $signed(coord_y) * $signed({1'b0, freq});
			seed_s1 <= seed;
			amp_s1  <= amp;
		end
	end

	// Floor of the scaled coordinate, then cell and fraction.
	always_comb begin
		sx = px_s1 >>> 12;
		sy = py_s1 >>> 12;
		cx = sx[COORD_FRAC_BITS+31:COORD_FRAC_BITS];
		cy = sy[COORD_FRAC_BITS+31:COORD_FRAC_BITS];
		tx = frac_q16(sx);
		ty = frac_q16(sy);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax0_s2  <= 32'(cx * HASH_MX);
			ax1_s2  <= 32'((cx + 32'd1) * HASH_MX);
			by0_s2  <= 32'(cy * HASH_MY);
			by1_s2  <= 32'((cy + 32'd1) * HASH_MY);
			t2x_s2  <= 32'(tx) * 32'(tx);
			t2y_s2  <= 32'(ty) * 32'(ty);
			tx_s2   <= tx;
			ty_s2   <= ty;
			seed_s2 <= seed_s1;
			amp_s2  <= amp_s1;
		end
	end

	// Corner order: (x0,y0), (x0+1,y0), (x0,y0+1), (x0+1,y0+1).
	always_comb begin
		hc[0] = seed_s2 ^ ax0_s2 ^ by0_s2;
		hc[1] = seed_s2 ^ ax1_s2 ^ by0_s2;
		hc[2] = seed_s2 ^ ax0_s2 ^ by1_s2;
		hc[3] = seed_s2 ^ ax1_s2 ^ by1_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				mix_s3[c] <= 32'((hc[c] ^ (hc[c] >> 13)) * HASH_MIX);
			end
			wx_s3  <= smooth(t2x_s2, tx_s2);
			wy_s3  <= smooth(t2y_s2, ty_s2);
			amp_s3 <= amp_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				n_s4[c] <= corner_value(mix_s3[c]);
			end
			wx_s4  <= wx_s3;
			wy_s4  <= wy_s3;
			amp_s4 <= amp_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r0_s5  <= blend(n_s4[0], n_s4[1], wx_s4);
			r1_s5  <= blend(n_s4[2], n_s4[3], wx_s4);
			wy_s5  <= wy_s4;
			amp_s5 <= amp_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s6   <= blend(r0_s5, r1_s5, wy_s5);
			amp_s6 <= amp_s5;
		end
	end

	// Maps [0, 1] onto [-1, 1]: twice the level minus one.
	assign v = $signed({1'b0, n_s6, 1'b0}) - 19'sd65536;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s7 <= PROD_W'(v * $signed({1'b0, amp_s6}));
			amp_s7  <= amp_s6;
		end
	end

	assign prod    = prod_s7;
	assign amp_out = amp_s7;

endmodule

>>> rtl/fvn_sum.sv
`timescale 1ns / 1ps

module fvn_sum (
	input  logic               clk,
	input  logic               en,
	input  logic [3:0]         octave_count,
	input  fvn_pkg::oct_prod_t prod [fvn_pkg::MAX_OCTAVES],
	input  logic [31:0]        amp [fvn_pkg::MAX_OCTAVES],
	output fvn_pkg::total_t    total,
	output fvn_pkg::norm_t     norm
);
	import fvn_pkg::*;

	logic [4:0] cnt;
	total_t     tot_s [SUM_LVLS+1][SUM_LEAVES];
	norm_t      nrm_s [SUM_LVLS+1][SUM_LEAVES];

	assign cnt = (5'(octave_count) > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES) : 5'(octave_count);

	// Octaves beyond the programmed count contribute nothing to either sum.
	for (genvar k = 0; k < SUM_LEAVES; k++) begin : g_leaf
		if (k < MAX_OCTAVES) begin : g_used
			always_ff @(posedge clk) begin
				if (en) begin
					tot_s[0][k] <= (5'(k) < cnt) ? total_t'(prod[k]) : '0;
					nrm_s[0][k] <= (5'(k) < cnt) ? norm_t'(amp[k]) : '0;
				end
			end
		end else begin : g_pad
			always_ff @(posedge clk) begin
				if (en) begin
					tot_s[0][k] <= '0;
					nrm_s[0][k] <= '0;
				end
			end
		end
	end

	for (genvar lv = 1; lv <= SUM_LVLS; lv++) begin : g_lvl
		for (genvar i = 0; i < (SUM_LEAVES >> lv); i++) begin : g_node
			always_ff @(posedge clk) begin
				if (en) begin
					tot_s[lv][i] <= tot_s[lv-1][2*i] + tot_s[lv-1][2*i+1];
					nrm_s[lv][i] <= nrm_s[lv-1][2*i] + nrm_s[lv-1][2*i+1];
				end
			end
		end
	end

	assign total = tot_s[SUM_LVLS][0];
	assign norm  = nrm_s[SUM_LVLS][0];

endmodule

>>> rtl/fvn_div.sv
`timescale 1ns / 1ps

module fvn_div (
	input  logic               clk,
	input  logic               en,
	input  fvn_pkg::total_t    total,
	input  fvn_pkg::norm_t     norm,
	output logic signed [15:0] noise_value
);
	import fvn_pkg::*;

	localparam int NUM_W = TOT_W;
	localparam int DEN_W = NORM_W + 1;
	localparam int CMP_W = NUM_W + 1;

	logic [NUM_W-1:0] mag;
	logic [NUM_W-1:0] num_s1;
	logic [DEN_W-1:0] den_s1;
	logic             neg_s1, zero_s1;

	logic [NUM_W-1:0]  rem_s  [Q_BITS+1];
	logic [Q_BITS-1:0] quo_s  [Q_BITS+1];
	logic [DEN_W-1:0]  den_s  [Q_BITS+1];
	logic              neg_s  [Q_BITS+1];
	logic              zero_s [Q_BITS+1];
	logic              ovf_s  [Q_BITS+1];

	logic              big;
	logic [Q_BITS-1:0] qf;
	logic signed [15:0] res_s;

	assign mag = total[TOT_W-1] ? NUM_W'(-total) : NUM_W'(total);

	// The quotient is (|total| + norm) / (2 * norm): halving with rounding away from zero.
	always_ff @(posedge clk) begin
		if (en) begin
			num_s1  <= mag + NUM_W'(norm);
			den_s1  <= {norm, 1'b0};
			neg_s1  <= total[TOT_W-1];
			zero_s1 <= (norm == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= num_s1;
			quo_s[0]  <= '0;
			den_s[0]  <= den_s1;
			neg_s[0]  <= neg_s1;
			zero_s[0] <= zero_s1;
			ovf_s[0]  <= CMP_W'(num_s1) >= (CMP_W'(den_s1) << Q_BITS);
		end
	end

	// One restoring step per stage, most significant quotient bit first.
	for (genvar i = 0; i < Q_BITS; i++) begin : g_step
		localparam int B = Q_BITS - 1 - i;
		logic [CMP_W-1:0] dsh;
		logic             ge;
		assign dsh = CMP_W'(den_s[i]) << B;
		assign ge  = CMP_W'(rem_s[i]) >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? NUM_W'(CMP_W'(rem_s[i]) - dsh) : rem_s[i];
				quo_s[i+1]  <= quo_s[i] | (ge ? (Q_BITS'(1) << B) : '0);
				den_s[i+1]  <= den_s[i];
				neg_s[i+1]  <= neg_s[i];
				zero_s[i+1] <= zero_s[i];
				ovf_s[i+1]  <= ovf_s[i];
			end
		end
	end

	assign qf  = quo_s[Q_BITS];
	assign big = ovf_s[Q_BITS] || qf[Q_BITS-1];

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s[Q_BITS]) begin
				res_s <= '0;
			end else if (big) begin
				res_s <= neg_s[Q_BITS] ? 16'sh8000 : 16'sh7FFF;
			end else begin
				res_s <= neg_s[Q_BITS] ? -$signed(qf) : $signed(qf);
			end
		end
	end

	assign noise_value = res_s;

endmodule

>>> rtl/fractal_value_noise_unit.sv
`timescale 1ns / 1ps

// Fractal value noise over a 2-D point.
// Input channel (in_valid/in_ready) carries one word per sample: coord_x and
// coord_y in signed Q16.16. Output channel (out_valid/out_ready) returns one word,
// noise_value in signed Q1.15, for every input word, in order.
// The APB port holds base_seed, octave_count, lacunarity and gain at byte offsets
// 0, 4, 8 and 12; write them only while no sample is in flight.
// The accepting edge loads the first of 8 stages that build the per-octave
// frequency and amplitude, 7 stages run the eight octave lanes in parallel,
// 4 stages gate and sum, and 19 stages hold the bit-per-stage divider and
// rounding, followed by the output register.
// Throughput is one word per cycle while the receiver keeps up.
// When the receiver stalls, one more word lands in a skid register; after that
// the whole pipeline freezes and in_ready drops until the output drains.
// Reset empties the pipeline and loads the register defaults (seed 0, four
// octaves, lacunarity 2.0, gain 0.5).
module fractal_value_noise_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] noise_value
);
	import fvn_pkg::*;

	logic [31:0] base_seed_q;
	logic [3:0]  octave_count_q;
	logic [15:0] lacunarity_q;
	logic [15:0] gain_q;

	logic        adv;
	logic [PIPE_LAT-1:0] vld_q;
	logic        push, take;
	logic        out_vld_q, skid_vld_q;
	logic signed [15:0] out_data_q, skid_data_q;

	logic signed [31:0] cx_s [MAX_OCTAVES];
	logic signed [31:0] cy_s [MAX_OCTAVES];
	logic [31:0] freq_s [MAX_OCTAVES][MAX_OCTAVES];
	logic [31:0] amp_s  [MAX_OCTAVES][MAX_OCTAVES];

	oct_prod_t   lane_prod [MAX_OCTAVES];
	logic [31:0] lane_amp  [MAX_OCTAVES];
	total_t      sum_total;
	norm_t       sum_norm;
	logic signed [15:0] div_res;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_seed_q    <= '0;
			octave_count_q <= 4'd4;
			lacunarity_q   <= 16'd8192;
			gain_q         <= 16'd2048;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_BASE_SEED:    base_seed_q    <= pwdata;
				REG_OCTAVE_COUNT: octave_count_q <= pwdata[3:0];
				REG_LACUNARITY:   lacunarity_q   <= pwdata[15:0];
				REG_GAIN:         gain_q         <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_BASE_SEED:    prdata = base_seed_q;
			REG_OCTAVE_COUNT: prdata = 32'(octave_count_q);
			REG_LACUNARITY:   prdata = 32'(lacunarity_q);
			REG_GAIN:         prdata = 32'(gain_q);
		endcase
	end

	// The pipeline only stops when the skid register is occupied.
	assign adv      = !skid_vld_q;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], in_valid};
		end
	end

	// Stage j computes the frequency and amplitude of octave j from octave j-1.
	for (genvar j = 0; j < MAX_OCTAVES; j++) begin : g_chain
		if (j == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (adv) begin
					cx_s[0] <= coord_x;
					cy_s[0] <= coord_y;
					for (int k = 0; k < MAX_OCTAVES; k++) begin
						freq_s[0][k] <= (k == 0) ? FREQ_ONE : '0;
						amp_s[0][k]  <= (k == 0) ? AMP_ONE : '0;
					end
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (adv) begin
					cx_s[j] <= cx_s[j-1];
					cy_s[j] <= cy_s[j-1];
					for (int k = 0; k < MAX_OCTAVES; k++) begin
						freq_s[j][k] <= (k == j) ? mul_sat(freq_s[j-1][j-1], lacunarity_q)
							: freq_s[j-1][k];
						amp_s[j][k]  <= (k == j) ? mul_sat(amp_s[j-1][j-1], gain_q)
							: amp_s[j-1][k];
					end
				end
			end
		end
	end

	for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_lane
		fvn_octave u_octave (
			.clk     (clk),
			.en      (adv),
			.coord_x (cx_s[MAX_OCTAVES-1]),
			.coord_y (cy_s[MAX_OCTAVES-1]),
			.freq    (freq_s[MAX_OCTAVES-1][k]),
			.seed    (32'(base_seed_q + 32'(k) * SEED_STEP)),
			.amp     (amp_s[MAX_OCTAVES-1][k]),
			.prod    (lane_prod[k]),
			.amp_out (lane_amp[k])
		);
	end

	fvn_sum u_sum (
		.clk          (clk),
		.en           (adv),
		.octave_count (octave_count_q),
		.prod         (lane_prod),
		.amp          (lane_amp),
		.total        (sum_total),
		.norm         (sum_norm)
	);

	fvn_div u_div (
		.clk         (clk),
		.en          (adv),
		.total       (sum_total),
		.norm        (sum_norm),
		.noise_value (div_res)
	);

	assign push = adv && vld_q[PIPE_LAT-1];
	assign take = out_vld_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			priority if (push && (!out_vld_q || take)) begin
				out_vld_q <= 1'b1;
			end else if (push) begin
				skid_vld_q <= 1'b1;
			end else if (take) begin
				out_vld_q  <= skid_vld_q;
				skid_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (push && (!out_vld_q || take)) begin
			out_data_q <= div_res;
		end else if (push) begin
			skid_data_q <= div_res;
		end else if (take && skid_vld_q) begin
			out_data_q <= skid_data_q;
		end
	end

	assign out_valid   = out_vld_q;
	assign noise_value = out_data_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid word held while output register is empty");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && !out_ready) |=> (skid_vld_q && $stable(skid_data_q)))
		else $error("skid word lost during output stall");

	a_overflow_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(push && out_vld_q && !out_ready) |=> skid_vld_q)
		else $error("pipeline word dropped while output stalled");

	a_frozen_valids: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("valid bits moved while pipeline was frozen");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import fvn_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int EXP_DEPTH   = 1024;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [3:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] coord_x;
	logic signed [31:0] coord_y;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] noise_value;

	fractal_value_noise_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .coord_x(coord_x), .coord_y(coord_y),
		.out_valid(out_valid), .out_ready(out_ready), .noise_value(noise_value)
	);

	// Shadow copy of the configuration registers.
	logic [31:0] seed_reg;
	logic [3:0]  octaves_reg;
	logic [15:0] lacun_reg;
	logic [15:0] gain_reg;

	// Expected words, written at input acceptance and read in order by the checker.
	logic signed [15:0] exp_mem [EXP_DEPTH];
	int                 exp_wr;
	int                 exp_rd;
	int                 mismatches;
	int                 cycles;
	bit                 steady_send;
	bit                 steady_recv;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR at cycle %0d: %s", cycles, msg);
		mismatches++;
	endtask

	function automatic logic [31:0] corner_hash24(input logic [31:0] cx, input logic [31:0] cy,
			input logic [31:0] seed);
		logic [31:0] h;
		h = seed ^ (cx * HASH_MX);
		h = h ^ (cy * HASH_MY);
		h = (h ^ (h >> 13)) * HASH_MIX;
		h = h ^ (h >> 16);
		return h & HASH_MASK;
	endfunction

	function automatic longint unsigned corner_level(input logic [31:0] cx,
			input logic [31:0] cy, input logic [31:0] seed);
		longint unsigned h;
		h = {32'd0, corner_hash24(cx, cy, seed)};
		return (h * 64'd65536 + 64'h7FFFFF) / 64'hFFFFFF;
	endfunction

	function automatic longint unsigned smoothstep_q16(input longint unsigned t);
		longint unsigned t2;
		t2 = t * t;
		return (t2 * (64'd196608 - 2 * t) + 64'h80000000) >> 32;
	endfunction

	function automatic longint unsigned blend_q16(input longint unsigned a,
			input longint unsigned b, input longint unsigned s);
		return (a * (64'd65536 - s) + b * s + 64'd32768) >> 16;
	endfunction

	// floor(coord * freq / 4096), two's complement modulo 2^64.
	function automatic logic [63:0] scale_coord_q(input logic signed [31:0] c,
			input logic [31:0] freq);
		logic signed [63:0] p;
		p = 64'(c) * $signed({32'd0, freq});
		return p >>> 12;
	endfunction

	function automatic longint unsigned octave_level(input logic [63:0] sx,
			input logic [63:0] sy, input logic [31:0] seed);
		logic [31:0]     x0;
		logic [31:0]     y0;
		longint unsigned wx;
		longint unsigned wy;
		longint unsigned top;
		longint unsigned bot;
		x0 = sx[47:16];
		y0 = sy[47:16];
		wx = smoothstep_q16({48'd0, sx[15:0]});
		wy = smoothstep_q16({48'd0, sy[15:0]});
		top = blend_q16(corner_level(x0, y0, seed), corner_level(x0 + 1, y0, seed), wx);
		bot = blend_q16(corner_level(x0, y0 + 1, seed),
			corner_level(x0 + 1, y0 + 1, seed), wx);
		return blend_q16(top, bot, wy);
	endfunction

	function automatic logic signed [15:0] fractal_noise(input logic signed [31:0] x,
			input logic signed [31:0] y);
		int              count;
		longint unsigned freq;
		longint unsigned amp;
		longint unsigned norm;
		longint unsigned mag;
		longint unsigned q;
		longint          total;
		longint          v;
		longint          res;
		logic [31:0]     seed;
		count = (octaves_reg > MAX_OCTAVES) ? MAX_OCTAVES : octaves_reg;
		freq = 4096;
		amp = 65536;
		norm = 0;
		total = 0;
		res = 0;
		for (int k = 0; k < count; k++) begin
			seed = seed_reg + k * SEED_STEP;
			v = longint'(2 * octave_level(scale_coord_q(x, freq[31:0]),
				scale_coord_q(y, freq[31:0]), seed)) - 65536;
			total += v * longint'(amp);
			norm += amp;
			amp = (amp * gain_reg) >> 12;
			if (amp > 64'hFFFFFFFF)
				amp = 64'hFFFFFFFF;
			freq = (freq * lacun_reg) >> 12;
			if (freq > 64'hFFFFFFFF)
				freq = 64'hFFFFFFFF;
		end
		if (norm > 0) begin
			mag = (total < 0) ? -total : total;
			q = (mag + norm) / (2 * norm);
			if (q > 32768)
				q = 32768;
			res = (total < 0) ? -longint'(q) : longint'(q);
			if (res > 32767)
				res = 32767;
		end
		return res[15:0];
	endfunction

	// Result checker; out_ready stalls are drawn per word.
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = steady_recv ? 0 : $urandom_range(0, 17);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (exp_rd == exp_wr) begin
				report_mismatch($sformatf("unexpected word noise_value=%0d", noise_value));
			end else begin
				if (noise_value !== exp_mem[exp_rd % EXP_DEPTH])
					report_mismatch($sformatf("noise_value got %0d expected %0d",
						noise_value, exp_mem[exp_rd % EXP_DEPTH]));
				exp_rd++;
			end
		end
	end

	task automatic send_point(input logic [31:0] x, input logic [31:0] y);
		int gap;
		gap = steady_send ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		coord_x <= x;
		coord_y <= y;
		do @(posedge clk); while (!in_ready);
		exp_mem[exp_wr % EXP_DEPTH] = fractal_noise(x, y);
		exp_wr++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (exp_rd != exp_wr)
			@(posedge clk);
		repeat (PIPE_LAT + 5) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_BASE_SEED:    seed_reg = value;
			REG_OCTAVE_COUNT: octaves_reg = value[3:0];
			REG_LACUNARITY:   lacun_reg = value[15:0];
			REG_GAIN:         gain_reg = value[15:0];
		endcase
	endtask

	task automatic set_config(input logic [31:0] seed, input logic [3:0] octs,
			input logic [15:0] lac, input logic [15:0] g);
		wait_drained();
		write_reg(REG_BASE_SEED, seed);
		write_reg(REG_OCTAVE_COUNT, {28'd0, octs});
		write_reg(REG_LACUNARITY, {16'd0, lac});
		write_reg(REG_GAIN, {16'd0, g});
	endtask

	task automatic test_reset_defaults();
		send_point(32'h0000_0000, 32'h0000_0000);
		send_point(32'h0001_8000, 32'hFFFE_4000);
		send_point(32'h7FFF_FFFF, 32'h8000_0000);
	endtask

	task automatic test_coord_extremes();
		set_config(32'hFFFF_FFFF, 4'd8, 16'd8192, 16'd2048);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_point(32'h8000_0000, 32'h8000_0000);
		send_point(32'h8000_0000, 32'h7FFF_FFFF);
		send_point(32'hFFFF_FFFF, 32'h0000_0001);
		send_point(32'h0000_FFFF, 32'hFFFF_0000);
	endtask

	task automatic test_octave_limits();
		// Zero octaves yields zero; counts above the maximum saturate.
		set_config(32'h1234_5678, 4'd0, 16'd8192, 16'd2048);
		send_point(32'h0003_2000, 32'h0005_7000);
		set_config(32'h1234_5678, 4'd15, 16'd8192, 16'd2048);
		send_point(32'h0003_2000, 32'h0005_7000);
		set_config(32'h1234_5678, 4'd1, 16'd8192, 16'd2048);
		send_point(32'h0003_2000, 32'h0005_7000);
	endtask

	task automatic test_gain_lacunarity_extremes();
		// Zero gain leaves only the first octave carrying weight.
		set_config(32'h0000_0000, 4'd8, 16'd0, 16'd0);
		send_point(32'h0002_4000, 32'hFFF0_1234);
		set_config(32'h0000_0000, 4'd8, 16'hFFFF, 16'hFFFF);
		send_point(32'h0002_4000, 32'hFFF0_1234);
		send_point(32'h7FFF_FFFF, 32'h8000_0000);
		set_config(32'hDEAD_BEEF, 4'd8, 16'd4096, 16'd4096);
		send_point(32'h0000_8000, 32'h0000_8000);
	endtask

	task automatic test_random_points();
		logic [31:0] x;
		logic [31:0] y;
		for (int phase = 0; phase < 10; phase++) begin
			set_config($urandom(), 4'($urandom_range(0, 15)),
				(phase % 3 == 0) ? 16'hFFFF : 16'($urandom()),
				(phase % 4 == 1) ? 16'd0 : 16'($urandom()));
			steady_send = (phase % 3 == 2);
			steady_recv = (phase % 4 == 3);
			for (int i = 0; i < 48; i++) begin
				case ($urandom_range(0, 2))
					0: begin
						x = $urandom();
						y = $urandom();
					end
					1: begin
						x = 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
						y = 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
					end
					default: begin
						x = {16'($urandom_range(0, 7) - 4),
							16'($urandom_range(0, 3) * 16'h5555)};
						y = {16'($urandom()), 16'hFFFF - 16'($urandom_range(0, 2))};
					end
				endcase
				send_point(x, y);
			end
		end
		steady_send = 1'b0;
		steady_recv = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		coord_x = '0;
		coord_y = '0;
		steady_send = 1'b0;
		steady_recv = 1'b0;
		seed_reg = 32'd0;
		octaves_reg = 4'd4;
		lacun_reg = 16'd8192;
		gain_reg = 16'd2048;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_coord_extremes();
		test_octave_limits();
		test_gain_lacunarity_extremes();
		test_random_points();
		wait_drained();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
